>>> src/hhpb_pkg.sv
package hhpb_pkg;

    localparam int HUE_W      = 8;
    localparam int BINCNT_W   = 6;
    localparam int PEAK_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd2;

    localparam logic [HUE_W-1:0]    RST_RANGE_LOW  = 8'd40;
    localparam logic [HUE_W-1:0]    RST_RANGE_HIGH = 8'd90;
    localparam logic [BINCNT_W-1:0] RST_BIN_COUNT  = 6'd20;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             last_pixel;
    } t_in_beat;

    typedef struct packed {
        logic [HUE_W-1:0]  band_lo;
        logic [HUE_W-1:0]  band_hi;
        logic [PEAK_W-1:0] peak_bin;
    } t_out_beat;

    typedef struct packed {
        logic inc;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic pass1;
        logic pass2;
    } t_scan_ctl;

endpackage

>>> src/hhpb_cell.sv
module hhpb_cell
    import hhpb_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 20,
    parameter int KW  = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [KW-1:0]    i_key,
    input  logic [HUE_W-1:0] i_span,
    input  logic [CW-1:0]    i_shift_in,
    output logic [CW-1:0]    o_cnt
);

    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_lb;
    logic [KW-1:0] r_ub;
    logic          w_hit;

    // bin edges in the scaled key domain
    always_ff @(posedge i_clk) begin
        r_lb <= KW'(IDX) * KW'(i_span);
        r_ub <= KW'(IDX + 1) * KW'(i_span);
    end

    assign w_hit = i_ctl.inc && (i_key >= r_lb) && (i_key < r_ub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.shift) begin
            r_cnt <= i_shift_in;
        end else if (w_hit && (r_cnt != {CW{1'b1}})) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_cnt = r_cnt;

endmodule

>>> src/hhpb_scan.sv
module hhpb_scan
    import hhpb_pkg::*;
#(
    parameter int CW = 20,
    parameter int IW = 5,
    parameter int NW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan_ctl     i_ctl,
    input  logic [IW-1:0] i_idx,
    input  logic [NW-1:0] i_n,
    input  logic [CW-1:0] i_cnt,
    output logic [IW-1:0] o_peak,
    output logic [IW-1:0] o_lo_idx,
    output logic          o_lo_fnd,
    output logic [IW-1:0] o_hi_idx,
    output logic          o_hi_fnd
);

    logic [CW-1:0]   r_mx;
    logic [CW-1:0]   r_mn;
    logic [CW-1:0]   r_diff;
    logic [IW-1:0]   r_peak;
    logic [IW-1:0]   r_lo_idx;
    logic [IW-1:0]   r_hi_idx;
    logic            r_lo_fnd;
    logic            r_hi_fnd;
    logic            w_in_use;
    logic [CW-1:0]   w_d;
    logic [CW+3:0]   w_d10;
    logic            w_below;

    assign w_in_use = NW'(i_idx) < i_n;
    assign w_d      = i_cnt - r_mn;
    // ten times the distance above the minimum
    assign w_d10    = {1'b0, w_d, 3'b000} + {3'b000, w_d, 1'b0};
    assign w_below  = w_d10 < (CW + 4)'(r_diff);

    always_ff @(posedge i_clk) begin
        r_diff <= r_mx - r_mn;
        if (i_ctl.pass1) begin
            if (i_idx == '0) begin
                r_mx   <= i_cnt;
                r_mn   <= i_cnt;
                r_peak <= '0;
            end else if (w_in_use) begin
                if (i_cnt > r_mx) begin
                    r_mx   <= i_cnt;
                    r_peak <= i_idx;
                end
                if (i_cnt < r_mn) begin
                    r_mn <= i_cnt;
                end
            end
        end
        if (i_ctl.pass2 && w_in_use && w_below) begin
            if (i_idx <= r_peak) begin
                r_lo_idx <= i_idx;
            end
            if ((i_idx >= r_peak) && !r_hi_fnd) begin
                r_hi_idx <= i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_fnd <= 1'b0;
            r_hi_fnd <= 1'b0;
        end else if (i_ctl.pass1 && (i_idx == '0)) begin
            r_lo_fnd <= 1'b0;
            r_hi_fnd <= 1'b0;
        end else if (i_ctl.pass2 && w_in_use && w_below) begin
            if (i_idx <= r_peak) begin
                r_lo_fnd <= 1'b1;
            end
            if (i_idx >= r_peak) begin
                r_hi_fnd <= 1'b1;
            end
        end
    end

    assign o_peak   = r_peak;
    assign o_lo_idx = r_lo_idx;
    assign o_lo_fnd = r_lo_fnd;
    assign o_hi_idx = r_hi_idx;
    assign o_hi_fnd = r_hi_fnd;

    a_lo_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_fnd |-> (r_lo_idx <= r_peak))
        else $error("lower stop bin above peak");

    a_hi_above_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi_fnd |-> (r_hi_idx >= r_peak))
        else $error("upper stop bin below peak");

endmodule

>>> src/hhpb_div.sv
module hhpb_div
    import hhpb_pkg::*;
#(
    parameter int NW = 6,
    parameter int KW = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KW-1:0]    i_num,
    input  logic [NW-1:0]    i_den,
    output logic             o_done,
    output logic [HUE_W-1:0] o_quo
);

    localparam int SW = $clog2(KW + 1);

    logic [NW-1:0] r_rem;
    logic [KW-1:0] r_quo;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   w_rem_sh;
    logic          w_ge;
    logic [NW-1:0] w_rem_nx;

    assign w_rem_sh = {r_rem, r_quo[KW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_den};
    assign w_rem_nx = w_ge ? NW'(w_rem_sh - {1'b0, i_den}) : NW'(w_rem_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_step <= SW'(KW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_rem_nx;
                r_quo  <= {r_quo[KW-2:0], w_ge};
                r_step <= r_step - SW'(1);
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[HUE_W-1:0];

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still stepping");

endmodule

>>> src/hue_histogram_peak_band_top.sv
// hue histogram peak band finder
// input channel: one pixel hue per beat (i_in_valid / o_in_ready), with a
// last_pixel flag closing the frame. pixels inside [range_low, range_high)
// are binned into a row of counter cells, one beat per clock, while counting.
// output channel: one beat per frame (o_out_valid / i_out_ready) carrying
// the lower and upper hue bounds of the dominant band and the peak bin.
// config port: i_cfg_we writes register i_cfg_idx (0 range_low, 1 range_high,
// 2 bin_count) at once; write only while no frame is in progress.
// after the last pixel beat the input stalls while the cell row is
// rotated once to find max, min and peak, rotated again with zero fill to
// find the stop bins and clear the counts, and two bounds go through a
// shared bit-serial divider of 8 + clog2(MAX_BINS+1) steps each.
// the result sits in an output register, so a stalled receiver holds the
// result while the next frame is counted; a further frame end waits for it.
// reset: config registers return to 40, 90, 20 and all counts are zero.
module hue_histogram_peak_band_top
    import hhpb_pkg::*;
#(
    parameter int MAX_BINS    = 32,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int NW = $clog2(MAX_BINS + 1);
    localparam int KW = HUE_W + NW;
    localparam int CW = COUNT_WIDTH;

    typedef enum logic [3:0] {
        S_COUNT, S_FLUSH, S_PASS1, S_GAP, S_PASS2,
        S_DLO_ST, S_DLO_W, S_DHI_ST, S_DHI_W, S_DONE
    } t_state;

    t_state           r_state;
    logic [HUE_W-1:0] r_rl;
    logic [HUE_W-1:0] r_rh;
    logic [BINCNT_W-1:0] r_bc;
    logic             r_p_hit;
    logic [KW-1:0]    r_p_key;
    logic [IW-1:0]    r_idx;
    logic [HUE_W-1:0] r_lo_q;
    logic [HUE_W-1:0] r_hi_q;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic             w_in_acc;
    logic [NW-1:0]    w_n;
    logic [HUE_W-1:0] w_span;
    logic             w_hit;
    t_cell_ctl        w_cell_ctl;
    t_scan_ctl        w_scan_ctl;
    logic [CW-1:0]    w_cnt [MAX_BINS];
    logic [IW-1:0]    w_peak;
    logic [IW-1:0]    w_lo_idx;
    logic [IW-1:0]    w_hi_idx;
    logic             w_lo_fnd;
    logic             w_hi_fnd;
    logic             w_div_start;
    logic [KW-1:0]    w_div_num;
    logic             w_div_done;
    logic [HUE_W-1:0] w_div_quo;
    logic             w_last_idx;
    logic             w_out_load;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl <= RST_RANGE_LOW;
            r_rh <= RST_RANGE_HIGH;
            r_bc <= RST_BIN_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_LOW:  r_rl <= i_cfg_data;
                CFG_RANGE_HIGH: r_rh <= i_cfg_data;
                CFG_BIN_COUNT:  r_bc <= BINCNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // bins in use, clamped to 1..MAX_BINS
    always_comb begin
        if (r_bc == '0) begin
            w_n = NW'(1);
        end else if (int'(r_bc) > MAX_BINS) begin
            w_n = NW'(MAX_BINS);
        end else begin
            w_n = NW'(r_bc);
        end
    end

    assign w_span   = r_rh - r_rl;
    assign o_in_ready = (r_state == S_COUNT);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_hit    = w_in_acc && (r_rh > r_rl) && (i_in_data.hue >= r_rl)
                      && (i_in_data.hue < r_rh);

    // scaled key: (hue - range_low) * bins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_hit <= 1'b0;
        end else begin
            r_p_hit <= w_hit;
        end
        r_p_key <= KW'(i_in_data.hue - r_rl) * KW'(w_n);
    end

    assign w_cell_ctl.inc   = r_p_hit;
    assign w_cell_ctl.shift = (r_state == S_PASS1) || (r_state == S_PASS2);
    assign w_scan_ctl.pass1 = (r_state == S_PASS1);
    assign w_scan_ctl.pass2 = (r_state == S_PASS2);

    for (genvar j = 0; j < MAX_BINS; j++) begin : g_cell
        logic [CW-1:0] w_sh_in;
        if (j < MAX_BINS - 1) begin : g_mid
            assign w_sh_in = w_cnt[j+1];
        end else begin : g_end
            assign w_sh_in = (r_state == S_PASS1) ? w_cnt[0] : '0;
        end
        hhpb_cell #(
            .IDX (j),
            .CW  (CW),
            .KW  (KW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_cell_ctl),
            .i_key      (r_p_key),
            .i_span     (w_span),
            .i_shift_in (w_sh_in),
            .o_cnt      (w_cnt[j])
        );
    end

    hhpb_scan #(
        .CW (CW),
        .IW (IW),
        .NW (NW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_scan_ctl),
        .i_idx    (r_idx),
        .i_n      (w_n),
        .i_cnt    (w_cnt[0]),
        .o_peak   (w_peak),
        .o_lo_idx (w_lo_idx),
        .o_lo_fnd (w_lo_fnd),
        .o_hi_idx (w_hi_idx),
        .o_hi_fnd (w_hi_fnd)
    );

    assign w_div_start = (r_state == S_DLO_ST) || (r_state == S_DHI_ST);
    assign w_div_num   = KW'(w_span) * KW'((r_state == S_DLO_ST) ? w_lo_idx : w_hi_idx);

    hhpb_div #(
        .NW (NW),
        .KW (KW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_n),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_last_idx = (r_idx == IW'(MAX_BINS - 1));
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COUNT;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_COUNT: begin
                    if (w_in_acc && i_in_data.last_pixel) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_idx   <= '0;
                    r_state <= S_PASS1;
                end
                S_PASS1: begin
                    if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_GAP;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_GAP: begin
                    r_state <= S_PASS2;
                end
                S_PASS2: begin
                    if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_DLO_ST;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DLO_ST: begin
                    r_state <= S_DLO_W;
                end
                S_DLO_W: begin
                    if (w_div_done) begin
                        r_lo_q  <= w_div_quo;
                        r_state <= S_DHI_ST;
                    end
                end
                S_DHI_ST: begin
                    r_state <= S_DHI_W;
                end
                S_DHI_W: begin
                    if (w_div_done) begin
                        r_hi_q  <= w_div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out.band_lo  <= w_lo_fnd ? (r_rl + r_lo_q) : r_rl;
                        r_out.band_hi  <= w_hi_fnd ? (r_rl + r_hi_q)
                                                   : (r_rh - HUE_W'(1));
                        r_out.peak_bin <= PEAK_W'(w_peak);
                        r_state        <= S_COUNT;
                    end
                end
                default: r_state <= S_COUNT;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_scan_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PASS1) && (r_idx == '0)) |-> $past(r_state == S_FLUSH))
        else $error("scan started without a flushed last pixel");

endmodule

>>> tb/tb_hue_histogram_peak_band_top.sv
`timescale 1ns / 1ps

module tb_hue_histogram_peak_band_top;
    import hhpb_pkg::*;

    localparam int MAX_BINS      = 32;
    localparam int COUNT_WIDTH   = 20;
    localparam int COUNT_MAX     = (1 << COUNT_WIDTH) - 1;
    localparam int THRESH_RATIO  = 10;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 800;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int REPORT_MAX    = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    t_in_beat              pix_beat = '0;
    logic                  band_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_RANGE_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_beat             o_out_data;

    // predictor state
    logic [COUNT_WIDTH-1:0] hist [MAX_BINS];
    logic [HUE_W-1:0]       hue_low = RST_RANGE_LOW;
    logic [HUE_W-1:0]       hue_high = RST_RANGE_HIGH;
    logic [BINCNT_W-1:0]    bin_setting = RST_BIN_COUNT;
    t_out_beat              expected_bands [$];

    int  bad_results = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    hue_histogram_peak_band_top #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (pix_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (pix_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (band_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int bins_in_use();
        if (bin_setting == 0)
            return 1;
        if (bin_setting > MAX_BINS)
            return MAX_BINS;
        return int'(bin_setting);
    endfunction

    function automatic void count_pixel(logic [HUE_W-1:0] h);
        int n;
        int idx;
        n = bins_in_use();
        if (hue_high <= hue_low || h < hue_low || h >= hue_high)
            return;
        idx = (int'(h) - int'(hue_low)) * n / (int'(hue_high) - int'(hue_low));
        if (idx >= n)
            return;
        if (hist[idx] != COUNT_MAX)
            hist[idx] = hist[idx] + COUNT_WIDTH'(1);
    endfunction

    function automatic int band_edge(int i, int n);
        return int'(hue_low) + (int'(hue_high) - int'(hue_low)) * i / n;
    endfunction

    // peak search, threshold walks both ways, then clear for the next frame
    function automatic t_out_beat close_band();
        int n;
        int peak;
        int i;
        int lo;
        int hi;
        longint unsigned top;
        longint unsigned floor_cnt;
        longint unsigned diff;
        t_out_beat r;
        n = bins_in_use();
        top = 64'(hist[0]);
        floor_cnt = 64'(hist[0]);
        peak = 0;
        for (i = 1; i < n; i++) begin
            if (64'(hist[i]) > top) begin
                top = 64'(hist[i]);
                peak = i;
            end
            if (64'(hist[i]) < floor_cnt)
                floor_cnt = 64'(hist[i]);
        end
        diff = top - floor_cnt;
        lo = int'(hue_low);
        for (i = peak; i >= 0; i--) begin
            if (64'(THRESH_RATIO) * (64'(hist[i]) - floor_cnt) < diff) begin
                lo = band_edge(i, n);
                break;
            end
        end
        hi = int'(hue_high) - 1;
        for (i = peak; i < n; i++) begin
            if (64'(THRESH_RATIO) * (64'(hist[i]) - floor_cnt) < diff) begin
                hi = band_edge(i, n);
                break;
            end
        end
        r.band_lo = lo[HUE_W-1:0];
        r.band_hi = hi[HUE_W-1:0];
        r.peak_bin = peak[PEAK_W-1:0];
        for (i = 0; i < MAX_BINS; i++)
            hist[i] = '0;
        return r;
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue(int lo, int hi, int centre, int spread);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (hi <= lo || r == 0)
            return HUE_W'($urandom_range(0, 255));
        if (r < 3)
            return HUE_W'($urandom_range(lo, hi - 1));
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[HUE_W-1:0];
    endfunction

    task automatic send_pixel(logic [HUE_W-1:0] h, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_beat.hue <= h;
        pix_beat.last_pixel <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        count_pixel(h);
        if (last)
            expected_bands.insert(expected_bands.size(), close_band());
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (expected_bands.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_band(logic [7:0] lo, logic [7:0] hi, logic [5:0] nb);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_RANGE_LOW;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx <= CFG_RANGE_HIGH;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx <= CFG_BIN_COUNT;
        cfg_data <= {2'b00, nb};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        hue_low = lo;
        hue_high = hi;
        bin_setting = nb;
    endtask

    task automatic test_reset_values();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd39, 1'b0);
        send_pixel(8'd40, 1'b0);
        send_pixel(8'd89, 1'b0);
        send_pixel(8'd90, 1'b0);
        send_pixel(8'd60, 1'b0);
        send_pixel(8'd61, 1'b1);
        settle();
    endtask

    task automatic test_register_extremes();
        program_band(8'd0, 8'd255, 6'd32);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b1);
        settle();
        program_band(8'd254, 8'd255, 6'd1);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd253, 1'b1);
        settle();
    endtask

    task automatic test_bin_clamp();
        program_band(8'd0, 8'd255, 6'd0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd200, 1'b1);
        settle();
        program_band(8'd0, 8'd255, 6'd63);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd200, 1'b1);
        settle();
    endtask

    task automatic test_empty_range();
        program_band(8'd100, 8'd100, 6'd8);
        send_pixel(8'd100, 1'b1);
        settle();
        program_band(8'd200, 8'd50, 6'd8);
        send_pixel(8'd120, 1'b1);
        settle();
        program_band(8'd0, 8'd0, 6'd8);
        send_pixel(8'd0, 1'b1);
        settle();
    endtask

    task automatic test_flat_histogram();
        program_band(8'd0, 8'd40, 6'd4);
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd15, 1'b0);
        send_pixel(8'd25, 1'b0);
        send_pixel(8'd35, 1'b1);
        settle();
    endtask

    // peak at an end bin with the minimum on one side only
    task automatic test_open_walks();
        program_band(8'd0, 8'd40, 6'd2);
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd30, 1'b0);
        send_pixel(8'd31, 1'b1);
        settle();
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd6, 1'b0);
        send_pixel(8'd30, 1'b1);
        settle();
    endtask

    task automatic test_back_to_back();
        program_band(8'd0, 8'd200, 6'd4);
        calm = 1'b1;
        repeat (40) send_pixel(8'd10, 1'b0);
        repeat (3) send_pixel(8'd60, 1'b0);
        send_pixel(8'd150, 1'b1);
        settle();
        calm = 1'b0;
    endtask

    task automatic test_random_frames();
        int counted;
        int frames;
        int len;
        int k;
        int lo;
        int hi;
        int centre;
        int spread;
        logic [HUE_W-1:0] h;
        logic [5:0] nb;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(0, 255);
                nb = 6'($urandom_range(0, 63));
            end else begin
                lo = $urandom_range(0, 200);
                hi = lo + int'($urandom_range(1, 255 - lo));
                nb = 6'($urandom_range(1, 32));
            end
            program_band(lo[7:0], hi[7:0], nb);
            calm = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 6);
            repeat (frames) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
                centre = (hi > lo) ? $urandom_range(lo, hi - 1) : $urandom_range(0, 255);
                spread = $urandom_range(0, 8);
                for (k = 1; k <= len; k++) begin
                    h = pick_hue(lo, hi, centre, spread);
                    send_pixel(h, k == len);
                    counted++;
                end
            end
            settle();
        end
        calm = 1'b0;
    endtask

    // receiver side: ready bursts with random stalls
    initial begin : band_sink
        int gap;
        @(posedge i_clk);
        forever begin
            band_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                band_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_bands
        t_out_beat want;
        if (i_rst_n && o_out_valid && band_ready) begin
            if (expected_bands.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("unexpected band beat: lo %0d hi %0d peak %0d",
                             o_out_data.band_lo, o_out_data.band_hi,
                             o_out_data.peak_bin);
            end else begin
                want = expected_bands.pop_front();
                if (o_out_data.band_lo !== want.band_lo ||
                    o_out_data.band_hi !== want.band_hi ||
                    o_out_data.peak_bin !== want.peak_bin) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("band mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 want.band_lo, want.band_hi, want.peak_bin,
                                 o_out_data.band_lo, o_out_data.band_hi,
                                 o_out_data.peak_bin);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_BINS; i++)
            hist[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_bin_clamp();
        test_empty_range();
        test_flat_histogram();
        test_open_walks();
        test_back_to_back();
        test_random_frames();
        settle();
        if (expected_bands.size() != 0)
            bad_results++;
        if (bad_results == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
src/hhpb_pkg.sv
src/hhpb_cell.sv
src/hhpb_scan.sv
src/hhpb_div.sv
src/hue_histogram_peak_band_top.sv
tb/tb_hue_histogram_peak_band_top.sv
